FILE: design/dxt1_pkg.sv
// Shared types, constants and helper functions of the DXT1 block decoder.
// No dependencies; every other file of the decoder imports this package.
`default_nettype none

package dxt1_pkg;

  // Depth of the block queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes (paddr[2]).
  typedef enum logic [0:0] {
    REG_COLOR_FORMAT = 1'b0,
    REG_SWAP_RED_BLUE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] endpoint0;
    logic [15:0] endpoint1;
    logic [31:0] index_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] pixel_number;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // One decoded block: the expanded palette and the pixel indices.
  typedef struct packed {
    color_t [3:0] pal;
    logic [31:0]  index_word;
  } blk_t;

  // floor(x / 3) for x < 256 by multiplication with the reciprocal 171/512.
  function automatic logic [6:0] div3(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return prod[15:9];
  endfunction

  // Rounded one-third blend: (2 * near + far + 1) / 3.
  function automatic logic [5:0] third(input logic [5:0] near, input logic [5:0] far);
    logic [7:0] s;
    s = {1'b0, near, 1'b0} + {2'b00, far} + 8'd1;
    return 6'(div3(s));
  endfunction

  // Rounded half blend, ties round up.
  function automatic logic [5:0] half(input logic [5:0] a, input logic [5:0] b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b} + 7'd1;
    return s[6:1];
  endfunction

  // Bit replication to 8 bits from a 6-bit or a 5-bit field.
  function automatic logic [7:0] widen(input logic [5:0] v, input logic six);
    return six ? {v, v[5:4]} : {v[4:0], v[4:2]};
  endfunction

endpackage

`default_nettype wire

FILE: design/dxt1_block_decoder.sv
// Top level of the DXT1 (BC1) block decoder: configuration registers and
// the front, queue and back parts. Uses dxt1_pkg, dxt1_front, dxt1_queue, dxt1_back.
//
//   Channel   Ports                                  Transaction
//   input     push, full, in_item                    push && !full
//   result    pop, empty, out_item                   pop && !empty
//   config    psel, penable, pwrite, paddr, pwdata,  psel && penable && pwrite
//             prdata, pready                         (pready is tied high)
//
// Each compressed block yields sixteen pixels, one per cycle unless the result
// side stalls, walked by the back part's pixel counter. A block passes the front
// holding register, the queue, the back block register and the result register.
// The back walks one block, the queue holds two more and the front one more,
// so up to four blocks may be accepted while the result side stalls; full
// rises after that.
// Reset is synchronous on rst_n; it empties the pipeline and restores
// color_format to RGB565 and swap_red_blue to off.
`default_nettype none

module dxt1_block_decoder
  import dxt1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic     color_format_r, color_format_nxt;
  logic     swap_red_blue_r, swap_red_blue_nxt;
  logic     cfg_wr;
  cfg_reg_t cfg_sel;
  logic     q_wr, q_rd, q_full, q_valid;
  blk_t     q_wdata, q_rdata;

  // Registers sit at byte addresses 0 and 4, so paddr[2] picks one of them.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_comb begin
    color_format_nxt  = color_format_r;
    swap_red_blue_nxt = swap_red_blue_r;
    prdata            = '0;
    case (cfg_sel)
      REG_COLOR_FORMAT: begin
        prdata = {31'b0, color_format_r};
        if (cfg_wr) begin
          color_format_nxt = pwdata[0];
        end
      end
      REG_SWAP_RED_BLUE: begin
        prdata = {31'b0, swap_red_blue_r};
        if (cfg_wr) begin
          swap_red_blue_nxt = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_format_r  <= 1'b1;
      swap_red_blue_r <= 1'b0;
    end else begin
      color_format_r  <= color_format_nxt;
      swap_red_blue_r <= swap_red_blue_nxt;
    end
  end

  // The front decodes endpoints into the palette as the block is taken in;
  // configuration is read live; the user must change it only while idle (unchecked).
  dxt1_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .color_format  (color_format_r),
    .swap_red_blue (swap_red_blue_r),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  // The queue lets the front keep taking blocks while the back is stalled.
  dxt1_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_valid (q_valid)
  );

  // The back loads the next block, if the queue holds one, in the cycle its last pixel
  // advances, so pixels of consecutive blocks follow without a gap.
  dxt1_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: design/dxt1_front.sv
// Front part of the DXT1 decoder: takes a compressed block, decides the mode
// and builds the expanded palette into a holding register. Uses dxt1_pkg.
`default_nettype none

module dxt1_front
  import dxt1_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  input  wire logic     color_format,
  input  wire logic     swap_red_blue,
  output logic          q_wr,
  output blk_t          q_wdata,
  input  wire logic     q_full
);

  logic       fr_valid_r, fr_valid_nxt;
  blk_t       fr_blk_r, fr_blk_nxt;
  logic       accept;
  logic       four;
  logic [5:0] r0, g0, b0, r1, g1, b1;
  logic [5:0] r2, g2, b2, r3, g3, b3;

  assign full    = fr_valid_r && q_full;
  assign accept  = push && !full;
  assign q_wr    = fr_valid_r && !q_full;
  assign q_wdata = fr_blk_r;

  // Palette build; the mode compares the raw endpoints before any swap.
  always_comb begin
    four = in_item.endpoint0 > in_item.endpoint1;
    r0 = {1'b0, in_item.endpoint0[4:0]};
    r1 = {1'b0, in_item.endpoint1[4:0]};
    if (color_format) begin
      g0 = in_item.endpoint0[10:5];
      g1 = in_item.endpoint1[10:5];
      b0 = {1'b0, in_item.endpoint0[15:11]};
      b1 = {1'b0, in_item.endpoint1[15:11]};
    end else begin
      g0 = {1'b0, in_item.endpoint0[9:5]};
      g1 = {1'b0, in_item.endpoint1[9:5]};
      b0 = {1'b0, in_item.endpoint0[14:10]};
      b1 = {1'b0, in_item.endpoint1[14:10]};
    end
    if (swap_red_blue) begin
      {r0, b0} = {b0, r0};
      {r1, b1} = {b1, r1};
    end
    if (four) begin
      r2 = third(r0, r1);
      g2 = third(g0, g1);
      b2 = third(b0, b1);
      r3 = third(r1, r0);
      g3 = third(g1, g0);
      b3 = third(b1, b0);
    end else begin
      r2 = half(r0, r1);
      g2 = half(g0, g1);
      b2 = half(b0, b1);
      r3 = '0;
      g3 = '0;
      b3 = '0;
    end
    fr_blk_nxt.index_word   = in_item.index_word;
    fr_blk_nxt.pal[0].red   = widen(r0, 1'b0);
    fr_blk_nxt.pal[0].green = widen(g0, color_format);
    fr_blk_nxt.pal[0].blue  = widen(b0, 1'b0);
    fr_blk_nxt.pal[1].red   = widen(r1, 1'b0);
    fr_blk_nxt.pal[1].green = widen(g1, color_format);
    fr_blk_nxt.pal[1].blue  = widen(b1, 1'b0);
    fr_blk_nxt.pal[2].red   = widen(r2, 1'b0);
    fr_blk_nxt.pal[2].green = widen(g2, color_format);
    fr_blk_nxt.pal[2].blue  = widen(b2, 1'b0);
    if (four) begin
      fr_blk_nxt.pal[3].red   = widen(r3, 1'b0);
      fr_blk_nxt.pal[3].green = widen(g3, color_format);
      fr_blk_nxt.pal[3].blue  = widen(b3, 1'b0);
    end else begin
      fr_blk_nxt.pal[3] = '0;
    end
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (q_wr) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_blk_r <= fr_blk_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/dxt1_queue.sv
// Short queue of decoded blocks between the front and back parts.
// Depth comes from dxt1_pkg::QDEPTH.
`default_nettype none

module dxt1_queue
  import dxt1_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire blk_t wdata,
  output logic      q_full,
  input  wire logic rd,
  output blk_t      rdata,
  output logic      q_valid
);

  blk_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = cnt_r == QCNT_W'(QDEPTH);
  assign q_valid = cnt_r != '0;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr && q_full))
    else $error("block queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd && !q_valid))
    else $error("block queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("block queue count beyond depth");

endmodule

`default_nettype wire

FILE: design/dxt1_back.sv
// Back part of the DXT1 decoder (uses dxt1_pkg): walks the sixteen indices
// of a decoded block and drives one pixel per cycle to out_r unless stalled.
`default_nettype none

module dxt1_back
  import dxt1_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire blk_t q_rdata,
  output logic      q_rd,
  output logic      empty,
  input  wire logic pop,
  output out_item_t out_item
);

  logic      busy_r, busy_nxt;
  blk_t      blk_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic      ovalid_r, ovalid_nxt;
  out_item_t out_r, pix;
  logic      adv, done, load;
  logic [1:0] sel;

  assign empty    = !ovalid_r;
  assign out_item = out_r;

  assign adv  = busy_r && (!ovalid_r || pop);
  assign done = adv && (cnt_r == 4'd15);
  assign load = q_valid && (!busy_r || done);
  assign q_rd = load;

  always_comb begin
    sel              = blk_r.index_word[{cnt_r, 1'b0} +: 2];
    pix.red          = blk_r.pal[sel].red;
    pix.green        = blk_r.pal[sel].green;
    pix.blue         = blk_r.pal[sel].blue;
    pix.pixel_number = cnt_r;
    pix.last         = cnt_r == 4'd15;
  end

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    if (pop && ovalid_r) begin
      ovalid_nxt = 1'b0;
    end
    if (adv) begin
      ovalid_nxt = 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= pix;
    end
    if (load) begin
      blk_r <= q_rdata;
    end
  end

  a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ovalid_r && !out_r.last) |=>
      (ovalid_r && out_r.pixel_number == $past(out_r.pixel_number) + 4'd1))
    else $error("pixels of a block not consecutive");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (out_r.last == (out_r.pixel_number == 4'd15)))
    else $error("last flag does not match pixel number");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || cnt_r == 4'd15))
    else $error("new block loaded while pixels remain");

endmodule

`default_nettype wire
